@@ rtl/core/slt_pkg.sv @@
package slt_pkg;

  // Width of the entries field on the result channel
  localparam int ENTRIES_W = 7;
  localparam int VALUE_W   = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_FULL       = 3'd2,
    ST_DUMP_ITEM  = 3'd3,
    ST_DUMP_EMPTY = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_DMP_RD,
    S_DMP_WR,
    S_DONE
  } state_t;

  // One result as handed from the sequencer to the output register
  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   item;
    logic [ENTRIES_W-1:0] entries;
    logic                 is_empty;
    logic                 last;
  } res_t;

endpackage

@@ rtl/core/slt_ram.sv @@
module slt_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [slt_pkg::VALUE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [slt_pkg::VALUE_W-1:0] rdata
);
  import slt_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/slt_seq.sv @@
module slt_seq #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [slt_pkg::VALUE_W-1:0] in_value,
  input  logic                        out_free,
  output logic                        res_push,
  output slt_pkg::res_t               res,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [slt_pkg::VALUE_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [slt_pkg::VALUE_W-1:0] mem_rdata
);
  import slt_pkg::*;

  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic               found_r, found_nxt;
  status_t            status_r, status_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [CW-1:0]      k_inc;
  logic [CW-1:0]      k_dec;

  assign k_inc = CW'(k_r + 1'b1);
  assign k_dec = CW'(k_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    k_nxt      = k_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    in_ready   = 1'b0;
    res_push   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = k_r[AW-1:0];
    mem_wdata  = value_r;
    mem_re     = 1'b0;
    mem_raddr  = k_r[AW-1:0];
    res.status   = status_r;
    res.item     = '0;
    res.entries  = ENTRIES_W'(fill_r);
    res.is_empty = (fill_r == '0);
    res.last     = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          value_nxt = in_value;
          found_nxt = 1'b0;
          unique case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              if (fill_r == FULL_CNT) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                k_nxt     = fill_r;
                state_nxt = S_INS_RD;
              end
            end
            CMD_REMOVE: begin
              k_nxt     = '0;
              state_nxt = S_REM_RD;
            end
            CMD_DUMP: begin
              if (fill_r == '0) begin
                status_nxt = ST_DUMP_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                k_nxt     = '0;
                state_nxt = S_DMP_RD;
              end
            end
            CMD_NOP: begin
              status_nxt = ST_DONE;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      // Insert walks down from the top: entries not less than the value move up one
      S_INS_RD: begin
        if (k_r == '0) begin
          mem_we     = 1'b1;
          mem_waddr  = '0;
          fill_nxt   = CW'(fill_r + 1'b1);
          status_nxt = ST_DONE;
          state_nxt  = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_dec[AW-1:0];
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        if ($signed(mem_rdata) >= $signed(value_r)) begin
          mem_wdata = mem_rdata;
          k_nxt     = k_dec;
          state_nxt = S_INS_RD;
        end else begin
          fill_nxt   = CW'(fill_r + 1'b1);
          status_nxt = ST_DONE;
          state_nxt  = S_DONE;
        end
      end

      // Remove walks up; after the match every entry moves down one
      S_REM_RD: begin
        if (k_r == fill_r) begin
          if (found_r) begin
            fill_nxt   = CW'(fill_r - 1'b1);
            status_nxt = ST_DONE;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_r[AW-1:0];
          state_nxt = S_REM_WR;
        end
      end

      S_REM_WR: begin
        priority if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = k_dec[AW-1:0];
          mem_wdata = mem_rdata;
          k_nxt     = k_inc;
          state_nxt = S_REM_RD;
        end else if (mem_rdata == value_r) begin
          found_nxt = 1'b1;
          k_nxt     = k_inc;
          state_nxt = S_REM_RD;
        end else if ($signed(mem_rdata) > $signed(value_r)) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          k_nxt     = k_inc;
          state_nxt = S_REM_RD;
        end
      end

      S_DMP_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_DMP_WR;
      end

      S_DMP_WR: begin
        res.status = ST_DUMP_ITEM;
        res.item   = mem_rdata;
        res.last   = (k_inc == fill_r);
        if (out_free) begin
          res_push = 1'b1;
          if (k_inc == fill_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_DMP_RD;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/sorted_list_table.sv @@
// Channel  Ports                                              Direction
// in       in_valid, in_ready, in_cmd, in_value               command in
// out      out_valid, out_ready, out_status, out_item,        results out
//          out_entries, out_is_empty, out_last
//
// Sequencing: a RAM read state, then a compare/write state, for each visited entry.
//   Insert visits entries from the top down until one is less than the value or
//   slot 0 is reached; remove reads entries up to the end of the list or until a
//   larger value ends the search; dump reads every entry; full, empty dump and
//   unused code go straight to their result.
// Reset: synchronous, rst_n low; the list comes back empty, no clearing pass.
// Stalls: a result sits in the output register while the next command is taken;
//   the sequencer only holds when it has a result to load and that register is full.
module sorted_list_table #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_item,
  output logic [6:0]  out_entries,
  output logic        out_is_empty,
  output logic        out_last
);
  import slt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic               out_valid_r;
  res_t               res_r;
  logic               out_free;
  logic               res_push;
  res_t               res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  slt_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_value  (in_value),
    .out_free  (out_free),
    .res_push  (res_push),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Reads and writes never meet on one entry in the same cycle: the sequencer
  // alternates a read state with a compare/write state.
  slt_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = res_r.status;
  assign out_item     = res_r.item;
  assign out_entries  = res_r.entries;
  assign out_is_empty = res_r.is_empty;
  assign out_last     = res_r.last;

  // Checks
  a_entries_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entries <= ENTRIES_W'(CAPACITY)))
    else $error("entries beyond capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entries == '0)))
    else $error("empty flag disagrees with entries");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DUMP_ITEM)) |-> (out_last && (out_item == '0)))
    else $error("non-dump result not a single zero-item transfer");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken while busy");

endmodule

@@ sim/tb_sorted_list_table.sv @@
`timescale 1ns / 1ps

module tb_sorted_list_table;
  import slt_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int HOLD_CYCLES  = 80;      // long receiver hold-off, forces input back-pressure
  localparam int TAIL_CYCLES  = 100;     // > worst single command (a pass over every stored entry)
  localparam int CYCLE_LIMIT  = 300000;

  // A command as queued for the driver
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] value;
  } list_cmd_t;

  // One result as the block should present it
  typedef struct {
    status_t     status;
    logic [31:0] item;
    logic [6:0]  entries;
    logic        is_empty;
    logic        last;
  } list_result_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd       = CMD_NOP;
  logic [31:0] in_value     = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_item;
  logic [6:0]  out_entries;
  logic        out_is_empty;
  logic        out_last;

  // Commands waiting for the driver, filled by the stimulus block
  list_cmd_t    cmd_backlog[$];
  // Results owed by the block, oldest first
  list_result_t owed_results[$];
  // Predicted list contents, ascending
  logic signed [31:0] sorted_vals[$];
  // Stimulus-side view of what is stored; steers removes towards hits
  logic [31:0]  held_vals[$];

  int mismatches = 0;
  int cycles     = 0;
  // Idling control, written by the stimulus block on falling edges only
  bit quiet_in   = 1'b0;
  bit quiet_out  = 1'b0;
  int hold_asks  = 0;

  // Receiver-side bookkeeping, owned by the monitor
  int hold_seen  = 0;
  int hold_left  = 0;
  int stall_left = 0;
  // Sender-side gap counter, owned by the driver
  int gap_left   = 0;

  sorted_list_table #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_item    (out_item),
    .out_entries (out_entries),
    .out_is_empty(out_is_empty),
    .out_last    (out_last)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Run-away guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sorted_list_table: errors");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic owe_result(status_t st, logic [31:0] item, logic last);
    list_result_t r;
    r.status   = st;
    r.item     = item;
    r.entries  = 7'(sorted_vals.size());
    r.is_empty = (sorted_vals.size() == 0);
    r.last     = last;
    owed_results.push_back(r);
  endtask

  // Sorted-list behaviour: works out the results one accepted command causes
  task automatic apply_list_cmd(cmd_t cmd, logic signed [31:0] v);
    int pos;
    pos = 0;
    // first position whose value is not less than v
    while (pos < sorted_vals.size() && sorted_vals[pos] < v) pos++;
    case (cmd)
      CMD_INSERT: begin
        if (sorted_vals.size() >= LIST_DEPTH) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else begin
          // new duplicate goes ahead of older equal values
          sorted_vals.insert(pos, v);
          owe_result(ST_DONE, '0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (pos >= sorted_vals.size() || sorted_vals[pos] != v) begin
          owe_result(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          sorted_vals.delete(pos);
          owe_result(ST_DONE, '0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (sorted_vals.size() == 0) begin
          owe_result(ST_DUMP_EMPTY, '0, 1'b1);
        end else begin
          foreach (sorted_vals[i])
            owe_result(ST_DUMP_ITEM, sorted_vals[i], i == sorted_vals.size() - 1);
        end
      end
      default: owe_result(ST_DONE, '0, 1'b1);   // unused code: no change
    endcase
  endtask

  // Driver: presents the backlog, one transfer at a time, with random gaps unless quiet_in
  always @(posedge clk) begin
    list_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      // channel free this edge: nothing shown, or the shown command transfers now
      if (gap_left > 0 || cmd_backlog.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        nxt = cmd_backlog.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= nxt.cmd;
        in_value <= nxt.value;
        gap_left = quiet_in ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // Monitor: checks each result transfer, predicts from each command transfer,
  // and drives out_ready with per-result stalls unless quiet_out, plus a long hold on request
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %0d item %0d",
                                    out_status, $signed(out_item)));
        end else begin
          want = owed_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_item !== want.item)
            report_mismatch($sformatf("item %0d, want %0d",
                                      $signed(out_item), $signed(want.item)));
          if (out_entries !== want.entries)
            report_mismatch($sformatf("entries %0d, want %0d", out_entries, want.entries));
          if (out_is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %b, want %b", out_is_empty, want.is_empty));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_last, want.last));
        end
        stall_left = quiet_out ? 0 : $urandom_range(0, 3);
      end

      // results of this command cannot appear before the next edge
      if (in_valid && in_ready)
        apply_list_cmd(cmd_t'(in_cmd), $signed(in_value));

      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end

      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Queue a command and keep the stimulus-side view of the contents in step
  task automatic queue_cmd(cmd_t cmd, logic [31:0] value);
    list_cmd_t c;
    int hit;
    c.cmd   = cmd;
    c.value = value;
    cmd_backlog.push_back(c);
    if (cmd == CMD_INSERT && held_vals.size() < LIST_DEPTH) begin
      held_vals.push_back(value);
    end else if (cmd == CMD_REMOVE) begin
      hit = -1;
      foreach (held_vals[i])
        if (hit < 0 && held_vals[i] == value) hit = i;
      if (hit >= 0) held_vals.delete(hit);
    end
  endtask

  // Extremes, a narrow band for duplicates, and full-range values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : 32'hffff_ffff;
      3, 4, 5: return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  // Random mix; removes mostly target values believed to be stored
  task automatic queue_random(int n, int ins_pct, int rem_pct);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct)
        queue_cmd(CMD_INSERT, pick_value());
      else if (r < ins_pct + rem_pct) begin
        if (held_vals.size() > 0 && $urandom_range(0, 3) != 0)
          queue_cmd(CMD_REMOVE, held_vals[$urandom_range(0, held_vals.size() - 1)]);
        else
          queue_cmd(CMD_REMOVE, pick_value());
      end else if (r < 97)
        queue_cmd(CMD_DUMP, $urandom());
      else
        queue_cmd(CMD_NOP, $urandom());
    end
  endtask

  task automatic wait_backlog_empty();
    while (cmd_backlog.size() != 0) @(negedge clk);
  endtask

  initial begin
    wait (rst_n === 1'b1);
    @(negedge clk);

    // Directed: empty-list cases, extremes, duplicates, unused code, full list
    queue_cmd(CMD_DUMP,   32'h1234_5678);   // dump of empty list
    queue_cmd(CMD_REMOVE, 32'h0000_0005);   // remove from empty list
    queue_cmd(CMD_INSERT, 32'h7fff_ffff);
    queue_cmd(CMD_INSERT, 32'h8000_0000);
    queue_cmd(CMD_INSERT, 32'h0000_0000);
    queue_cmd(CMD_INSERT, 32'hffff_ffff);
    queue_cmd(CMD_INSERT, 32'h0000_0005);
    queue_cmd(CMD_INSERT, 32'h0000_0005);   // duplicate
    queue_cmd(CMD_NOP,    32'hdead_beef);
    queue_cmd(CMD_DUMP,   32'hffff_ffff);
    queue_cmd(CMD_REMOVE, 32'h0000_0005);   // first of the equal pair
    queue_cmd(CMD_REMOVE, 32'h0000_0006);   // absent, between stored values
    queue_cmd(CMD_REMOVE, 32'h8000_0000);
    // fill to capacity, then one more to hit the full-list drop
    for (int k = 0; k < 12; k++)
      queue_cmd(CMD_INSERT, 32'h0000_0100 - k * 3);
    queue_cmd(CMD_INSERT, 32'h8000_0000);
    queue_cmd(CMD_DUMP,   32'h0000_0000);
    wait_backlog_empty();

    // Growing list with random idling on both sides
    queue_random(70, 55, 25);
    wait_backlog_empty();

    // Back-to-back stretch: no idling anywhere
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    queue_random(50, 35, 45);
    wait_backlog_empty();

    // Receiver holds off while the sender keeps offering
    quiet_out = 1'b0;
    hold_asks++;
    queue_random(40, 40, 30);
    wait_backlog_empty();

    // Draining list, idling back on
    quiet_in = 1'b0;
    queue_random(43, 30, 50);

    while (cmd_backlog.size() != 0 || in_valid || owed_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb_sorted_list_table: clean");
    end else begin
      $display("tb_sorted_list_table: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/slt_pkg.sv
rtl/core/slt_ram.sv
rtl/core/slt_seq.sv
rtl/core/sorted_list_table.sv
sim/tb_sorted_list_table.sv
